FILE: rtl/ascending_sort_engine_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ascending sort engine
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASCENDING_SORT_ENGINE_ASSERT_SVH
`define ASCENDING_SORT_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ase_pkg.sv
// ---------------------------------------------------------------------------
// Ascending sort engine package
// Shared payload types, status struct and default parameter values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ase_pkg;

	localparam int VALUE_W        = 16;
	localparam int DEF_MAX_ITEMS  = 64;
	localparam int DEF_VALUE_BITS = 16;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] sorted_value;
		logic               end_of_list;
		logic               overflowed;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic sorting;
		logic emitting;
	} ase_status_t;

endpackage

FILE: rtl/ase_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ase_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ase_cmpx.sv
// ---------------------------------------------------------------------------
// Compare-exchange unit
// Orders two unsigned values and flags when they were out of order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ase_cmpx #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] lo,
	output logic [W-1:0] hi,
	output logic         swap
);

	assign swap = (a > b);
	assign lo   = swap ? b : a;
	assign hi   = swap ? a : b;

endmodule

FILE: rtl/ase_ctrl.sv
// ---------------------------------------------------------------------------
// Sort sequencer
// Loads the store, runs bubble passes through the shared compare-exchange
// unit and streams the sorted store out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ase_ctrl import ase_pkg::*; #(
	parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	localparam int IDX_W     = $clog2(MAX_ITEMS),
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  in_item_t              item,
	output out_item_t             result,
	output logic                  strobe,
	output ase_status_t           status,
	output logic                  we,
	output logic [IDX_W-1:0]      waddr,
	output logic [VALUE_BITS-1:0] wdata,
	output logic [IDX_W-1:0]      raddr,
	input  logic [VALUE_BITS-1:0] rdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PSTART = 3'd1;
	localparam logic [2:0] ST_PFIRST = 3'd2;
	localparam logic [2:0] ST_PSCAN  = 3'd3;
	localparam logic [2:0] ST_PEND   = 3'd4;
	localparam logic [2:0] ST_OSTART = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      bound_q;
	logic [IDX_W-1:0]      idx_q;
	logic [VALUE_BITS-1:0] carry_q;
	logic                  swap_q;
	logic                  ovf_q;

	logic                  full;
	logic [CNT_W-1:0]      n_next;
	logic                  scan_last;
	logic                  out_last;
	logic [VALUE_BITS-1:0] cmp_lo;
	logic [VALUE_BITS-1:0] cmp_hi;
	logic                  cmp_swap;

	// The carry register holds the largest value seen so far in the pass;
	// each step retires the smaller of carry and the next element.
	ase_cmpx #(.W(VALUE_BITS)) u_cmpx (
		.a    (carry_q),
		.b    (rdata),
		.lo   (cmp_lo),
		.hi   (cmp_hi),
		.swap (cmp_swap)
	);

	assign full      = (count_q == CNT_W'(MAX_ITEMS));
	assign n_next    = full ? count_q : count_q + CNT_W'(1);
	assign scan_last = (CNT_W'(idx_q) == bound_q - CNT_W'(1));
	assign out_last  = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !full) begin
					we    = 1'b1;
					waddr = count_q[IDX_W-1:0];
					wdata = VALUE_BITS'(item.value);
				end
			end
			ST_PSTART: raddr = '0;
			ST_PFIRST: raddr = IDX_W'(1);
			ST_PSCAN: begin
				we    = 1'b1;
				waddr = idx_q - IDX_W'(1);
				wdata = cmp_lo;
				raddr = idx_q + IDX_W'(1);
			end
			ST_PEND: begin
				we    = 1'b1;
				waddr = bound_q[IDX_W-1:0] - IDX_W'(1);
				wdata = carry_q;
			end
			ST_OSTART: raddr = '0;
			ST_OUT:    raddr = idx_q + IDX_W'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			bound_q <= '0;
			idx_q   <= '0;
			swap_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (item.last) begin
							bound_q <= n_next;
							state_q <= (n_next > CNT_W'(1)) ? ST_PSTART : ST_OSTART;
						end
					end
				end
				ST_PSTART: begin
					swap_q  <= 1'b0;
					state_q <= ST_PFIRST;
				end
				ST_PFIRST: begin
					idx_q   <= IDX_W'(1);
					state_q <= ST_PSCAN;
				end
				ST_PSCAN: begin
					swap_q <= swap_q | cmp_swap;
					if (scan_last) begin
						state_q <= ST_PEND;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_PEND: begin
					// A clean pass, or a pass over only the first two slots, ends the sort.
					if (!swap_q || bound_q == CNT_W'(2)) begin
						state_q <= ST_OSTART;
					end else begin
						bound_q <= bound_q - CNT_W'(1);
						state_q <= ST_PSTART;
					end
				end
				ST_OSTART: begin
					idx_q   <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The carry register is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_PFIRST) begin
			carry_q <= rdata;
		end else if (state_q == ST_PSCAN) begin
			carry_q <= cmp_hi;
		end
	end

	assign strobe              = (state_q == ST_OUT);
	assign result.sorted_value = VALUE_W'(rdata);
	assign result.end_of_list  = out_last;
	assign result.overflowed   = ovf_q;

	assign status.busy     = (state_q != ST_IDLE);
	assign status.sorting  = (state_q == ST_PSTART) || (state_q == ST_PFIRST)
		|| (state_q == ST_PSCAN) || (state_q == ST_PEND);
	assign status.emitting = strobe;

endmodule

FILE: rtl/ascending_sort_engine.sv
// ---------------------------------------------------------------------------
// Ascending sort engine
// Buffers a list of unsigned values and returns it sorted in ascending order.
// ---------------------------------------------------------------------------
// Values load one per cycle, one per start/item transaction; busy stays low
// while a list is loading. The transaction flagged last starts the sort (or,
// for a single value, the output) and raises busy. Sorting runs bubble passes
// through a single compare-exchange unit against a one-read, one-write store;
// passes stop at the first pass without a swap or once a pass covers only two
// slots, so a list that arrives in order sorts in a single pass. The n results
// then leave one per cycle after a read startup state, each marked by strobe
// for exactly one cycle; the receiver cannot stall them and must take every
// one. Values beyond the store's capacity are dropped and every result of
// that list carries overflowed. No clearing pass runs after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascending_sort_engine_assert.svh"

module ascending_sort_engine import ase_pkg::*; #(
	parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output out_item_t result,
	output logic      strobe
);

	localparam int IDX_W = $clog2(MAX_ITEMS);

	ase_status_t           status;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [IDX_W-1:0]      raddr;
	logic [VALUE_BITS-1:0] rdata;

	ase_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ase_ctrl #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.result (result),
		.strobe (strobe),
		.status (status),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	assign busy = status.busy;

	// Results only appear during a run, never while passes are still going.
	`ASE_ASSERT_IMPL(a_strobe_busy, clk, arst_n, strobe, busy && !status.sorting)
	// The final result of a run returns the block to idle.
	`ASE_ASSERT_NEXT(a_end_idle, clk, arst_n, strobe && result.end_of_list, !busy && !strobe)
	// A loaded value that does not end the list leaves the block ready.
	`ASE_ASSERT_NEXT(a_load_ready, clk, arst_n, start && !busy && !item.last, !busy)
	// Ending the list always leads into sorting or output.
	`ASE_ASSERT_NEXT(a_last_busy, clk, arst_n, start && !busy && item.last, busy && !strobe)

endmodule
